// ===== hdl/bpe_pkg.sv =====
package bpe_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int T_FRAC_BITS = 16;
    localparam int T_WIDTH     = T_FRAC_BITS + 1;
    localparam int NUM_AXES    = 3;
    localparam int POINT_WIDTH = NUM_AXES * COORD_WIDTH;

    localparam logic [T_WIDTH-1:0] ONE_T = T_WIDTH'(1) << T_FRAC_BITS;

    localparam logic INTERP_LINEAR = 1'b0;
    localparam logic INTERP_EASE   = 1'b1;

    localparam logic KIND_QUAD  = 1'b0;
    localparam logic KIND_CUBIC = 1'b1;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic [NUM_AXES-1:0][COORD_WIDTH-1:0] vec_t;
    typedef logic [T_WIDTH-1:0] weight_t;

    typedef struct packed {
        logic                   kind;
        logic [POINT_WIDTH-1:0] start_point;
        logic [POINT_WIDTH-1:0] end_point;
        logic [POINT_WIDTH-1:0] control_one;
        logic [POINT_WIDTH-1:0] control_two;
        logic [T_WIDTH-1:0]     param_t;
    } in_word_t;

    typedef struct packed {
        coord_t point_x;
        coord_t point_y;
        coord_t point_z;
    } out_word_t;

endpackage

// ===== hdl/bpe_lerp.sv =====
module bpe_lerp
    import bpe_pkg::*;
(
    input  logic    aclk,
    input  logic    en,
    input  weight_t weight,
    input  vec_t    a,
    input  vec_t    b,
    output vec_t    r
);

    localparam int DIFF_W = COORD_WIDTH + 1;
    localparam int PROD_W = DIFF_W + T_WIDTH + 1;

    logic signed [DIFF_W-1:0] diff [NUM_AXES];
    logic signed [PROD_W-1:0] prod [NUM_AXES];
    logic        [DIFF_W-1:0] sum  [NUM_AXES];
    vec_t r_reg;
    vec_t r_next;

    // a + floor(s * (b - a) / 2^T_FRAC_BITS); result stays between a and b
    always_comb begin
        for (int i = 0; i < NUM_AXES; i++) begin
            diff[i] = $signed({b[i][COORD_WIDTH-1], b[i]})
                    - $signed({a[i][COORD_WIDTH-1], a[i]});
            prod[i] = PROD_W'($signed({1'b0, weight})) * PROD_W'(diff[i]);
            sum[i]  = {a[i][COORD_WIDTH-1], a[i]}
                    + prod[i][T_FRAC_BITS+COORD_WIDTH:T_FRAC_BITS];
            r_next[i] = sum[i][COORD_WIDTH-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            r_reg <= r_next;
        end
    end

    assign r = r_reg;

endmodule

// ===== hdl/bezier_point_eval_top.sv =====
// channel  | ports                          | word
// ---------+--------------------------------+---------------------------------
// input    | s_valid, s_ready, s_data       | kind, four points, param_t
// result   | m_valid, m_ready, m_data       | point_x, point_y, point_z
// config   | cfg_we, cfg_wdata              | interp_mode
//
// Four register stages: weight, then three interpolation levels.
// One word per cycle sustained while m_ready stays high; each stage holds its own valid bit.
// A stage empties into the next when that one is empty or moving, so bubbles collapse.
// Quadratic words run level one with weight zero, which passes the points through.
// aresetn is synchronous, active low; it clears valid bits and interp_mode.
module bezier_point_eval_top
    import bpe_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      cfg_we,
    input  logic      cfg_wdata,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_word_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_data
);

    logic    mode_reg;
    logic    v0_reg, v1_reg, v2_reg, v3_reg;
    logic    rdy0, rdy1, rdy2, rdy3;

    weight_t t_sat;
    logic [2*T_WIDTH-1:0] t_sq;
    weight_t s0_next;

    weight_t s0_reg, s1_reg, s2_reg;
    logic    kind0_reg;
    vec_t    p0_reg, p1_reg, p2_reg, p3_reg;
    weight_t w1;

    vec_t    q0, q1, q2, r0, r1, res;

    assign rdy3 = !v3_reg || m_ready;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;
    assign rdy0 = !v0_reg || rdy1;
    assign s_ready = rdy0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= INTERP_LINEAR;
        end else if (cfg_we) begin
            mode_reg <= cfg_wdata;
        end
    end

    // weight stage
    always_comb begin
        t_sat = (s_data.param_t > ONE_T) ? ONE_T : s_data.param_t;
        t_sq  = (2*T_WIDTH)'(t_sat) * (2*T_WIDTH)'(t_sat);
        if (mode_reg == INTERP_EASE) begin
            s0_next = t_sq[T_FRAC_BITS+T_WIDTH-1:T_FRAC_BITS];
        end else begin
            s0_next = t_sat;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (rdy0) v0_reg <= s_valid;
            if (rdy1) v1_reg <= v0_reg;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy0 && s_valid) begin
            s0_reg    <= s0_next;
            kind0_reg <= s_data.kind;
            p0_reg    <= vec_t'(s_data.start_point);
            p1_reg    <= vec_t'(s_data.control_one);
            p2_reg    <= (s_data.kind == KIND_CUBIC) ? vec_t'(s_data.control_two)
                                                     : vec_t'(s_data.end_point);
            p3_reg    <= vec_t'(s_data.end_point);
        end
        if (rdy1 && v0_reg) s1_reg <= s0_reg;
        if (rdy2 && v1_reg) s2_reg <= s1_reg;
    end

    assign w1 = (kind0_reg == KIND_CUBIC) ? s0_reg : '0;

    bpe_lerp u_l1a (.aclk(aclk), .en(rdy1 && v0_reg), .weight(w1),
                    .a(p0_reg), .b(p1_reg), .r(q0));
    bpe_lerp u_l1b (.aclk(aclk), .en(rdy1 && v0_reg), .weight(w1),
                    .a(p1_reg), .b(p2_reg), .r(q1));
    bpe_lerp u_l1c (.aclk(aclk), .en(rdy1 && v0_reg), .weight(w1),
                    .a(p2_reg), .b(p3_reg), .r(q2));

    bpe_lerp u_l2a (.aclk(aclk), .en(rdy2 && v1_reg), .weight(s1_reg),
                    .a(q0), .b(q1), .r(r0));
    bpe_lerp u_l2b (.aclk(aclk), .en(rdy2 && v1_reg), .weight(s1_reg),
                    .a(q1), .b(q2), .r(r1));

    bpe_lerp u_l3 (.aclk(aclk), .en(rdy3 && v2_reg), .weight(s2_reg),
                   .a(r0), .b(r1), .r(res));

    assign m_valid        = v3_reg;
    assign m_data.point_x = coord_t'(res[0]);
    assign m_data.point_y = coord_t'(res[1]);
    assign m_data.point_z = coord_t'(res[2]);

`ifndef NO_ASSERTIONS
    a_accept_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> v0_reg)
        else $error("accepted word did not enter weight stage");

    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !v0_reg |-> s_ready)
        else $error("input stalled with empty weight stage");

    a_hold_l2: assert property (@(posedge aclk) disable iff (!aresetn)
        (v2_reg && !rdy3) |=> (v2_reg && $stable(r0) && $stable(r1)))
        else $error("stalled level two word lost or changed");

    a_weight_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        v0_reg |-> (s0_reg <= ONE_T))
        else $error("weight above one");
`endif

endmodule
